>>> design/sorted_set_table_defines.svh
// Assertion macros for the checker file of sorted_set_table.
`ifndef SORTED_SET_TABLE_DEFINES_SVH
`define SORTED_SET_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SST_ASSERT_NOW(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (con)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SST_ASSERT_NEXT(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (con)) \
    else $error(msg);

`endif

>>> design/sst_pkg.sv
// Types and constants of the sorted set table.
`default_nettype none

package sst_pkg;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_CHK,
    ST_DECIDE,
    ST_SHIFT,
    ST_INS,
    ST_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic srch_rd;
    logic cmp;
    logic chk_rd;
    logic chk;
    logic start_up;
    logic start_down;
    logic set_full;
    logic shift;
    logic ins_wr;
    logic commit;
  } sst_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic lo_lt_hi;
    logic lo_lt_cnt;
    logic is_ins;
    logic is_del;
    logic found;
    logic full;
    logic n_zero;
    logic pend;
    logic up;
    logic out_free;
  } sst_sts_t;

endpackage

`default_nettype wire

>>> design/sst_req_if.sv
// Request channel: operation code and value.
`default_nettype none

interface sst_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

>>> design/sst_rsp_if.sv
// Response channel: found flag, element count and status.
`default_nettype none

interface sst_rsp_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [6:0] count;
  logic       status;

  modport source (output valid, output found, output count, output status, input ready);
  modport sink (input valid, input found, input count, input status, output ready);
endinterface

`default_nettype wire

>>> design/sst_datapath.sv
// Datapath: store memory, search bounds, shift pointer, count and response register.
`default_nettype none

module sst_datapath #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  sst_pkg::sst_cmd_t  cmd_i,
  output sst_pkg::sst_sts_t  sts_o,
  input  wire [1:0]          func_i,
  input  wire signed [31:0]  value_i,
  input  wire                out_ready_i,
  output logic               out_valid_o,
  output logic               found_o,
  output logic [6:0]         count_o,
  output logic               status_o
);

  logic [31:0]        mem [DEPTH];

  logic [1:0]         func_q;
  logic signed [31:0] value_q;
  logic [CW-1:0]      lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      n_q, n_d;
  logic [CW-1:0]      mid;
  logic [AW-1:0]      r_q, r_d;
  logic [AW-1:0]      ra_q;
  logic               up_q, up_d;
  logic               pend_q, pend_d;
  logic               found_q, found_d;
  logic               status_q, status_d;
  logic signed [31:0] rdata_q;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic               out_valid_q;
  logic               out_found_q;
  logic [6:0]         out_count_q;
  logic               out_status_q;
  logic               is_ins, is_del;

  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign is_ins = (func_q == sst_pkg::FUNC_INSERT);
  assign is_del = (func_q == sst_pkg::FUNC_DELETE);

  // Read port.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = r_q;
    if (cmd_i.srch_rd) begin
      rd_en   = 1'b1;
      rd_addr = mid[AW-1:0];
    end else if (cmd_i.chk_rd) begin
      rd_en   = 1'b1;
      rd_addr = lo_q[AW-1:0];
    end else if (cmd_i.shift && (n_q != '0)) begin
      rd_en   = 1'b1;
      rd_addr = r_q;
    end
  end

  // Write port.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = up_q ? AW'(ra_q + 1'b1) : AW'(ra_q - 1'b1);
    wr_data = rdata_q;
    if (cmd_i.ins_wr) begin
      wr_en   = 1'b1;
      wr_addr = lo_q[AW-1:0];
      wr_data = value_q;
    end else if (cmd_i.shift && pend_q) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
      ra_q    <= rd_addr;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      value_q <= value_i;
    end
  end

  always_comb begin
    lo_d     = lo_q;
    hi_d     = hi_q;
    found_d  = found_q;
    status_d = status_q;
    up_d     = up_q;
    r_d      = r_q;
    n_d      = n_q;
    pend_d   = pend_q;
    count_d  = count_q;
    if (cmd_i.load) begin
      lo_d     = '0;
      hi_d     = count_q;
      found_d  = 1'b0;
      status_d = 1'b0;
    end
    if (cmd_i.cmp) begin
      if (rdata_q < value_q) begin
        lo_d = CW'(mid + 1'b1);
      end else begin
        hi_d = mid;
      end
    end
    if (cmd_i.chk) begin
      found_d = (rdata_q == value_q);
    end
    if (cmd_i.set_full) begin
      status_d = 1'b1;
    end
    if (cmd_i.start_up) begin
      up_d   = 1'b1;
      r_d    = AW'(count_q - 1'b1);
      n_d    = count_q - lo_q;
      pend_d = 1'b0;
    end
    if (cmd_i.start_down) begin
      up_d   = 1'b0;
      r_d    = AW'(lo_q + 1'b1);
      n_d    = CW'(count_q - lo_q - 1'b1);
      pend_d = 1'b0;
    end
    if (cmd_i.shift) begin
      pend_d = (n_q != '0);
      if (n_q != '0) begin
        n_d = n_q - 1'b1;
        r_d = up_q ? AW'(r_q - 1'b1) : AW'(r_q + 1'b1);
      end
    end
    if (cmd_i.commit) begin
      if (is_ins && !found_q && !status_q) begin
        count_d = count_q + 1'b1;
      end else if (is_del && found_q) begin
        count_d = count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q        <= '0;
      hi_q        <= '0;
      found_q     <= 1'b0;
      status_q    <= 1'b0;
      up_q        <= 1'b0;
      r_q         <= '0;
      n_q         <= '0;
      pend_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      found_q  <= found_d;
      status_q <= status_d;
      up_q     <= up_d;
      r_q      <= r_d;
      n_q      <= n_d;
      pend_q   <= pend_d;
      count_q  <= count_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_found_q  <= found_q;
      out_count_q  <= 7'(count_d);
      out_status_q <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign count_o     = out_count_q;
  assign status_o    = out_status_q;

  assign sts_o.lo_lt_hi  = (lo_q < hi_q);
  assign sts_o.lo_lt_cnt = (lo_q < count_q);
  assign sts_o.is_ins    = is_ins;
  assign sts_o.is_del    = is_del;
  assign sts_o.found     = found_q;
  assign sts_o.full      = (count_q == CW'(DEPTH));
  assign sts_o.n_zero    = (n_q == '0);
  assign sts_o.pend      = pend_q;
  assign sts_o.up        = up_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

>>> design/sst_ctrl.sv
// Controller: sequences search, found check, shift, insert write and response.
`default_nettype none

module sst_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  sst_pkg::sst_sts_t  sts_i,
  output sst_pkg::sst_cmd_t  cmd_o
);

  sst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sst_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sst_pkg::ST_SRCH;
        end
      end
      sst_pkg::ST_SRCH: begin
        if (sts_i.lo_lt_hi) begin
          cmd_o.srch_rd = 1'b1;
          state_d       = sst_pkg::ST_CMP;
        end else if (sts_i.lo_lt_cnt) begin
          cmd_o.chk_rd = 1'b1;
          state_d      = sst_pkg::ST_CHK;
        end else begin
          state_d = sst_pkg::ST_DECIDE;
        end
      end
      sst_pkg::ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = sst_pkg::ST_SRCH;
      end
      sst_pkg::ST_CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = sst_pkg::ST_DECIDE;
      end
      sst_pkg::ST_DECIDE: begin
        state_d = sst_pkg::ST_DONE;
        if (sts_i.is_ins && !sts_i.found) begin
          if (sts_i.full) begin
            cmd_o.set_full = 1'b1;
          end else begin
            cmd_o.start_up = 1'b1;
            state_d        = sst_pkg::ST_SHIFT;
          end
        end else if (sts_i.is_del && sts_i.found) begin
          cmd_o.start_down = 1'b1;
          state_d          = sst_pkg::ST_SHIFT;
        end
      end
      sst_pkg::ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.n_zero && !sts_i.pend) begin
          state_d = sts_i.up ? sst_pkg::ST_INS : sst_pkg::ST_DONE;
        end
      end
      sst_pkg::ST_INS: begin
        cmd_o.ins_wr = 1'b1;
        state_d      = sst_pkg::ST_DONE;
      end
      sst_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = sst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/sorted_set_table.sv
// A lookup or a no-op runs the binary search and the found check; an insert or a delete
// that moves entries also shifts the store, and a stalled response holds the table.
// One request at a time, the next taken the cycle after the response is registered;
// the store shifts one entry per cycle. Reset clears the element count and control
// state; the store itself is not cleared.
`default_nettype none

module sorted_set_table #(
  parameter int DEPTH = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  sst_req_if.sink     req_i,
  sst_rsp_if.source   rsp_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sst_pkg::sst_cmd_t cmd;
  sst_pkg::sst_sts_t sts;
  logic              in_ready;

  sst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sst_datapath #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .func_i      (req_i.func),
    .value_i     (req_i.value),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .found_o     (rsp_o.found),
    .count_o     (rsp_o.count),
    .status_o    (rsp_o.status)
  );

  assign req_i.ready = in_ready;

endmodule

`default_nettype wire

>>> design/sst_checker.sv
// Port-level checks of the sorted set table, bound to the top level.
`default_nettype none
`include "sorted_set_table_defines.svh"

module sst_checker #(
  parameter int DEPTH = 64
) (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       req_valid_i,
  input wire       req_ready_i,
  input wire       rsp_valid_i,
  input wire       rsp_ready_i,
  input wire       rsp_found_i,
  input wire [6:0] rsp_count_i,
  input wire       rsp_status_i
);

  `SST_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_found_i) && $stable(rsp_count_i) && $stable(rsp_status_i), "stalled response changed")
  `SST_ASSERT_NEXT(a_one_at_a_time, req_valid_i && req_ready_i, !req_ready_i, "request taken while busy")
  `SST_ASSERT_NOW(a_full_not_found, rsp_valid_i && rsp_status_i, !rsp_found_i, "full reject on present value")
  `SST_ASSERT_NOW(a_full_count, rsp_valid_i && rsp_status_i, rsp_count_i == 7'(DEPTH), "full reject below capacity")

endmodule

bind sorted_set_table sst_checker #(.DEPTH(DEPTH)) u_sst_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_found_i  (rsp_o.found),
  .rsp_count_i  (rsp_o.count),
  .rsp_status_i (rsp_o.status)
);

`default_nettype wire
